// ===== rtl/sem_pkg.sv =====
// Shared types and constants for the RGB Sobel edge magnitude block.
// Used by sem_ctrl, sem_datapath and sobel_edge_magnitude_rgb. No dependencies.
package sem_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 12;   // signed Gx / Gy accumulator
    localparam int SUM_W     = 21;   // Gx^2 + Gy^2
    localparam int ROOT_W    = 8;
    localparam int REM_W     = 12;
    localparam int SRC_W     = 16;
    localparam int SQRT_STEPS = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

    // item kinds on the input channel
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // window columns, read one per cycle
    localparam logic [1:0] COL_LEFT  = 2'd0;
    localparam logic [1:0] COL_MID   = 2'd1;
    localparam logic [1:0] COL_RIGHT = 2'd2;

    localparam logic [SUM_W-1:0]  SAT_LIMIT = 21'd65280;
    localparam logic [ROOT_W-1:0] MAG_MAX   = 8'd255;

    typedef logic [PIX_W-1:0] chan_t;

    // red in the lowest byte
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        logic       cfg_wr;
        logic       pix_wr;
        logic       rd_issue;
        logic [1:0] rd_step;
        logic       square;
        logic       sqrt_step;
        logic       load;
    } dp_cmd_t;

    typedef struct packed {
        logic result_ready;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/sem_ctrl.sv =====
// Sequencer for the Sobel edge magnitude block: accepts items and configuration writes and steps the
// datapath through window read, squaring, square root and result load. Uses sem_pkg.
module sem_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_mode,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sem_pkg::dp_status_t  status,
    output sem_pkg::dp_cmd_t     cmd
);
    import sem_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_ACC    = 3'd3;
    localparam logic [2:0] ST_SQUARE = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_LOAD   = 3'd6;

    localparam logic [2:0] SQRT_LAST = 3'(SQRT_STEPS - 1);

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] emit_cnt_reg, emit_cnt_next;
    logic [1:0] limit_reg, limit_next;

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        emit_cnt_next = emit_cnt_reg;
        limit_next    = limit_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        cfg_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_wr = 1'b1;
                end else if (s_tvalid) begin
                    cmd.pix_wr    = (s_mode == MODE_PIXEL);
                    limit_next    = (s_mode == MODE_PIXEL) ? 2'd2 : 2'd1;
                    emit_cnt_next = 2'd0;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.result_ready && (emit_cnt_reg < limit_reg)) begin
                    step_next  = 3'd0;
                    state_next = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                cmd.rd_step  = step_reg[1:0];
                if (step_reg[1:0] == COL_RIGHT) begin
                    state_next = ST_ACC;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_ACC: begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                step_next  = 3'd0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_LOAD;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_LOAD: begin
                if (status.out_free) begin
                    cmd.load      = 1'b1;
                    emit_cnt_next = emit_cnt_reg + 2'd1;
                    state_next    = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= 3'd0;
            emit_cnt_reg <= 2'd0;
            limit_reg    <= 2'd0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            emit_cnt_reg <= emit_cnt_next;
            limit_reg    <= limit_next;
        end
    end

endmodule

// ===== rtl/sem_datapath.sv =====
// Datapath of the Sobel edge magnitude block: frame registers, positions,
// three row memories, Gx/Gy accumulators, square root and output register. Uses sem_pkg.
module sem_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sem_pkg::dp_cmd_t              cmd,
    output sem_pkg::dp_status_t           status,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
    input  sem_pkg::pixel_t               pix_in,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output sem_pkg::pixel_t               m_tdata,
    output logic                          m_tlast
);
    import sem_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // frame size registers and their effective values
    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = RW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(frame_height_reg);
        end
    end

    // positions; rm = row modulo 3, selects the row memory
    logic [AW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [1:0]    in_rm_reg, out_rm_reg;

    logic [CW-1:0] in_col_w, out_col_p1, nc;
    logic [RW-1:0] out_row_p1, nr;
    logic          last_pos, up_ok, dn_ok;
    logic          res_ready;

    always_comb begin
        in_col_w   = CW'(in_col_reg);
        out_col_p1 = CW'(out_col_reg) + CW'(1);
        out_row_p1 = out_row_reg + RW'(1);
        nc         = (out_col_p1 < w_eff) ? out_col_p1 : (w_eff - CW'(1));
        nr         = (out_row_p1 < h_eff) ? out_row_p1 : (h_eff - RW'(1));
        last_pos   = (out_row_p1 == h_eff) && (out_col_p1 == w_eff);
        up_ok      = (out_row_reg != '0);
        dn_ok      = (out_row_p1 < h_eff);
        res_ready  = (out_row_reg < h_eff) &&
            ((in_row_reg > nr) || ((in_row_reg == nr) && (in_col_w > nc)));
    end

    // pixel write position: a complete frame restarts at the origin
    logic          restart_in;
    logic [AW-1:0] wr_col;
    logic [RW-1:0] wr_row;
    logic [1:0]    wr_rm;
    logic [CW-1:0] wr_col_p1;

    always_comb begin
        restart_in = (in_row_reg >= h_eff);
        wr_col     = restart_in ? '0 : in_col_reg;
        wr_row     = restart_in ? '0 : in_row_reg;
        wr_rm      = restart_in ? 2'd0 : in_rm_reg;
        wr_col_p1  = CW'(wr_col) + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_rm_reg   <= 2'd0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_rm_reg  <= 2'd0;
        end else if (cmd.cfg_wr) begin
            if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    frame_width_reg <= cfg_data;
                end else begin
                    frame_height_reg <= cfg_data;
                end
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_rm_reg   <= 2'd0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_rm_reg  <= 2'd0;
            end
        end else if (cmd.pix_wr) begin
            if (restart_in) begin
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_rm_reg  <= 2'd0;
            end
            if (wr_col_p1 >= w_eff) begin
                in_col_reg <= '0;
                in_row_reg <= wr_row + RW'(1);
                in_rm_reg  <= (wr_rm == 2'd2) ? 2'd0 : wr_rm + 2'd1;
            end else begin
                in_col_reg <= AW'(wr_col_p1);
                in_row_reg <= wr_row;
                in_rm_reg  <= wr_rm;
            end
        end else if (cmd.load) begin
            if (last_pos) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_rm_reg   <= 2'd0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_rm_reg  <= 2'd0;
            end else if (out_col_p1 >= w_eff) begin
                out_col_reg <= '0;
                out_row_reg <= out_row_p1;
                out_rm_reg  <= (out_rm_reg == 2'd2) ? 2'd0 : out_rm_reg + 2'd1;
            end else begin
                out_col_reg <= AW'(out_col_p1);
            end
        end
    end

    // row memories, one per row modulo 3
    pixel_t        upper_line  [MAX_WIDTH];
    pixel_t        middle_line [MAX_WIDTH];
    pixel_t        lower_line  [MAX_WIDTH];
    pixel_t        rd0_reg, rd1_reg, rd2_reg;
    logic [AW-1:0] rd_addr;

    assign rd_addr = out_col_reg + AW'(cmd.rd_step) - AW'(1);

    always_ff @(posedge aclk) begin
        if (cmd.pix_wr && wr_rm == 2'd0) begin
            upper_line[wr_col] <= pix_in;
        end
        if (cmd.rd_issue) begin
            rd0_reg <= upper_line[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_wr && wr_rm == 2'd1) begin
            middle_line[wr_col] <= pix_in;
        end
        if (cmd.rd_issue) begin
            rd1_reg <= middle_line[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pix_wr && wr_rm == 2'd2) begin
            lower_line[wr_col] <= pix_in;
        end
        if (cmd.rd_issue) begin
            rd2_reg <= lower_line[rd_addr];
        end
    end

    // column flags travel with the read data
    logic       rd_vld_reg;
    logic [1:0] rd_step_reg;
    logic       rd_colok_reg;
    logic       colok;

    always_comb begin
        case (cmd.rd_step)
            COL_LEFT:  colok = (out_col_reg != '0);
            COL_RIGHT: colok = (out_col_p1 < w_eff);
            default:   colok = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_issue;
        end
        rd_step_reg  <= cmd.rd_step;
        rd_colok_reg <= colok;
    end

    function automatic pixel_t pick(input logic [1:0] k, input pixel_t p0,
                                    input pixel_t p1, input pixel_t p2);
        pixel_t p;
        case (k)
            2'd0:    p = p0;
            2'd1:    p = p1;
            default: p = p2;
        endcase
        return p;
    endfunction

    // rows above, centre and below of the current column
    pixel_t     px_a, px_b, px_c;
    logic [1:0] a_idx, c_idx;

    always_comb begin
        a_idx = (out_rm_reg == 2'd0) ? 2'd2 : out_rm_reg - 2'd1;
        c_idx = (out_rm_reg == 2'd2) ? 2'd0 : out_rm_reg + 2'd1;
        px_a  = (rd_colok_reg && up_ok) ? pick(a_idx, rd0_reg, rd1_reg, rd2_reg) : '0;
        px_b  = rd_colok_reg ? pick(out_rm_reg, rd0_reg, rd1_reg, rd2_reg) : '0;
        px_c  = (rd_colok_reg && dn_ok) ? pick(c_idx, rd0_reg, rd1_reg, rd2_reg) : '0;
    end

    // per-channel Gx / Gy accumulation, square and square root
    logic signed [ACC_W-1:0] gx_reg [3];
    logic signed [ACC_W-1:0] gy_reg [3];
    logic                    sat_reg  [3];
    logic [SRC_W-1:0]        src_reg  [3];
    logic [REM_W-1:0]        rem_reg  [3];
    logic [ROOT_W-1:0]       root_reg [3];
    chan_t                   mag [3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic [9:0]              s1;
        logic signed [ACC_W-1:0] d, gx_add, gy_add;
        logic signed [2*ACC_W-1:0] px2, py2;
        logic [SUM_W-1:0]        sum;
        logic [REM_W-1:0]        rem_sh, trial;

        always_comb begin
            s1 = {2'b00, px_a[ch*PIX_W +: PIX_W]} + {1'b0, px_b[ch*PIX_W +: PIX_W], 1'b0}
               + {2'b00, px_c[ch*PIX_W +: PIX_W]};
            d  = $signed({4'b0000, px_c[ch*PIX_W +: PIX_W]})
               - $signed({4'b0000, px_a[ch*PIX_W +: PIX_W]});
            case (rd_step_reg)
                COL_LEFT:  gx_add = -$signed({2'b00, s1});
                COL_RIGHT: gx_add = $signed({2'b00, s1});
                default:   gx_add = '0;
            endcase
            gy_add = (rd_step_reg == COL_MID) ? (d <<< 1) : d;
            px2    = gx_reg[ch] * gx_reg[ch];
            py2    = gy_reg[ch] * gy_reg[ch];
            sum    = SUM_W'(px2) + SUM_W'(py2);
            rem_sh = {rem_reg[ch][REM_W-3:0], src_reg[ch][SRC_W-1 -: 2]};
            trial  = {2'b00, root_reg[ch], 2'b01};
            if (sat_reg[ch]) begin
                mag[ch] = MAG_MAX;
            end else if (rem_reg[ch] > REM_W'(root_reg[ch])) begin
                mag[ch] = root_reg[ch] + ROOT_W'(1);
            end else begin
                mag[ch] = root_reg[ch];
            end
        end

        always_ff @(posedge aclk) begin
            if (rd_vld_reg) begin
                if (rd_step_reg == COL_LEFT) begin
                    gx_reg[ch] <= gx_add;
                    gy_reg[ch] <= gy_add;
                end else begin
                    gx_reg[ch] <= gx_reg[ch] + gx_add;
                    gy_reg[ch] <= gy_reg[ch] + gy_add;
                end
            end
            if (cmd.square) begin
                sat_reg[ch]  <= (sum > SAT_LIMIT);
                src_reg[ch]  <= sum[SRC_W-1:0];
                rem_reg[ch]  <= '0;
                root_reg[ch] <= '0;
            end else if (cmd.sqrt_step) begin
                src_reg[ch] <= {src_reg[ch][SRC_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[ch]  <= rem_sh - trial;
                    root_reg[ch] <= {root_reg[ch][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[ch]  <= rem_sh;
                    root_reg[ch] <= {root_reg[ch][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    logic m_tvalid_reg;

    assign status   = '{result_ready: res_ready, out_free: (!m_tvalid_reg || m_tready)};
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.load) begin
            m_tdata.red   <= mag[0];
            m_tdata.green <= mag[1];
            m_tdata.blue  <= mag[2];
            m_tlast       <= last_pos;
        end
    end

endmodule

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the RGB Sobel edge magnitude block (3x3 kernel, zero padding).
// Instantiates sem_ctrl and sem_datapath; uses sem_pkg.
//
// Usage:
//   s_ channel: one item per handshake. s_tuser = 0 carries a pixel in raster
//   order, s_tuser = 1 is a drain item that flushes one pending result.
//   m_ channel: gradient magnitudes per channel, raster order; m_tlast marks
//   the result of the frame's last pixel. A result leaves once its 3x3
//   neighbourhood has arrived; the last row's results need drain items.
//   cfg channel: index 0 = frame width, index 1 = frame height (11 bits).
//   Write only while idle; a write to either index restarts the frame.
// Sequence: an item is taken only while idle; the block then checks for a ready
//   result and, per result, does 3 memory reads of one window column each,
//   accumulate, square, 8 square-root steps and load, then checks again. Each
//   channel has its own square-root unit; each row memory has one read port, so
//   the window columns are read one after another.
// Reset clears positions, sets both frame sizes to 1024 and empties the
//   output register. If the receiver stalls, a finished result waits in the
//   output register and the block stops at the next load until it is taken.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [23:0]                   s_tdata,
    // s_tuser: mode
    input  logic                          s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [23:0]                   m_tdata,
    // m_tlast: frame_end
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]     cfg_data
);
    import sem_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    pixel_t     pix_in;
    pixel_t     pix_out;

    assign pix_in  = s_tdata;
    assign m_tdata = pix_out;

    sem_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_mode    (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (pix_out),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== dv/sobel_edge_magnitude_rgb_tb.sv =====
// Self-checking testbench for sobel_edge_magnitude_rgb: streams RGB frames,
// predicts Sobel magnitudes on the fly and compares every result item.
// Depends on rtl/sem_pkg.sv and rtl/sobel_edge_magnitude_rgb.sv.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_tb;
    import sem_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int FRAME_ROWS = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 48;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SOBEL_K [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};

    typedef struct {
        logic   mode;
        pixel_t px;
    } stream_item_t;

    typedef struct {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  frame_end;
    } magnitude_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [23:0]          s_tdata = '0;
    logic                 s_tuser = MODE_PIXEL;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    sobel_edge_magnitude_rgb DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    pixel_t       row_ring [3][LINE_DEPTH];
    logic [CFG_W-1:0] width_reg = FRAME_WIDTH_RST;
    logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
    int unsigned  col_in, row_in, next_out;

    stream_item_t pending_items [$];
    magnitude_t   expected_mags [$];
    int           mismatches = 0;
    int           items_taken = 0;
    int           idle_cycles = 0;
    bit           item_taken = 0;
    bit           cfg_taken = 0;

    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic chan_t round_root(int unsigned s);
        int unsigned n;
        n = 0;
        if (s > 65280) return MAG_MAX;
        for (int b = 8; b >= 0; b--)
            if ((n | (1 << b)) * (n | (1 << b)) <= s) n = n | (1 << b);
        if (s > n * n + n) n++;
        return chan_t'(n);
    endfunction

    function automatic bit result_due(int unsigned w, int unsigned h);
        int unsigned r, c, nr, nc;
        if (next_out >= w * h) return 0;
        r  = next_out / w;
        c  = next_out % w;
        nr = (r + 1 < h) ? r + 1 : h - 1;
        nc = (c + 1 < w) ? c + 1 : w - 1;
        return (row_in * w + col_in) > (nr * w + nc);
    endfunction

    function automatic void emit_magnitude(int unsigned w, int unsigned h);
        int         gx [3];
        int         gy [3];
        int         r, c, v;
        pixel_t     p;
        magnitude_t m;
        r = next_out / w;
        c = next_out % w;
        gx = '{0, 0, 0};
        gy = '{0, 0, 0};
        for (int dr = -1; dr <= 1; dr++) begin
            if (r + dr < 0 || r + dr >= int'(h)) continue;
            for (int dc = -1; dc <= 1; dc++) begin
                if (c + dc < 0 || c + dc >= int'(w)) continue;
                p = row_ring[(r + dr) % 3][c + dc];
                for (int ch = 0; ch < 3; ch++) begin
                    v = (ch == 0) ? p.red : (ch == 1) ? p.green : p.blue;
                    gx[ch] += v * SOBEL_K[dr + 1][dc + 1];
                    gy[ch] += v * SOBEL_K[dc + 1][dr + 1];
                end
            end
        end
        m.red       = round_root(gx[0] * gx[0] + gy[0] * gy[0]);
        m.green     = round_root(gx[1] * gx[1] + gy[1] * gy[1]);
        m.blue      = round_root(gx[2] * gx[2] + gy[2] * gy[2]);
        m.frame_end = (next_out == w * h - 1);
        expected_mags.push_back(m);
        next_out++;
        if (next_out >= w * h) begin
            col_in = 0; row_in = 0; next_out = 0;
        end
    endfunction

    function automatic void predict_item(logic mode, pixel_t px);
        int unsigned w, h, n;
        w = eff_size(width_reg, LINE_DEPTH);
        h = eff_size(height_reg, FRAME_ROWS);
        if (mode == MODE_DRAIN) begin
            if (result_due(w, h)) emit_magnitude(w, h);
            return;
        end
        if (row_in >= h || col_in >= w) begin
            col_in = 0; row_in = 0; next_out = 0;
        end
        row_ring[row_in % 3][col_in] = px;
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        n = 0;
        while (n < 2 && result_due(w, h)) begin
            emit_magnitude(w, h);
            n++;
        end
    endfunction

    // rising edge: accept items, check results, apply register writes, watchdog
    always @(posedge aclk) begin
        bit moved;
        moved = 0;
        if (aresetn && s_tvalid && s_tready) begin
            predict_item(s_tuser, pixel_t'(s_tdata));
            item_taken = 1;
            items_taken++;
            moved = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1;
            if (expected_mags.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                magnitude_t e;
                e = expected_mags.pop_front();
                if (m_tdata[7:0] !== e.red || m_tdata[15:8] !== e.green ||
                    m_tdata[23:16] !== e.blue || m_tlast !== e.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: exp r %0d g %0d b %0d last %b, ",
                                  "got r %0d g %0d b %0d last %b"},
                                 e.red, e.green, e.blue, e.frame_end,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
                end
            end
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
                if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
                else height_reg = cfg_data;
                col_in = 0; row_in = 0; next_out = 0;
            end
            cfg_taken = 1;
            moved = 1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || item_taken)) begin
            item_taken = 0;
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                stream_item_t it;
                it = pending_items.pop_front();
                s_tdata  <= it.px;
                s_tuser  <= it.mode;
                s_tvalid <= 1'b1;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: the stall pattern is redrawn at random from four styles, plus one long hold-off
    int  ready_cycle = 0;
    int  ready_style = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(negedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 256 == 0) ready_style = $urandom_range(0, 3);
        if (!hold_done && items_taken >= 200) begin
            hold_done = 1;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (ready_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 0);
                2: m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= ((ready_cycle / 7) % 2 == 0);
            endcase
        end
    end

    task automatic add_pixel(pixel_t p);
        pending_items.push_back('{MODE_PIXEL, p});
    endtask

    task automatic add_drains(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back('{MODE_DRAIN, pixel_t'($urandom)});
    endtask

    // run of random pixels with no drain items
    task automatic add_pixels(int n);
        for (int i = 0; i < n; i++) add_pixel(pixel_t'($urandom));
    endtask

    // whole frame of random pixels followed by enough drain items
    task automatic add_frame(int unsigned w, int unsigned h);
        for (int unsigned i = 0; i < w * h; i++) add_pixel(pixel_t'($urandom));
        add_drains(w + 2);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_mags.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        cfg_taken = 0;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    initial begin
        int unsigned w, h, n;
        col_in = 0; row_in = 0; next_out = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: 3x3 frames with extreme values, drain with nothing ready
        set_frame(3, 3);
        add_drains(2);
        for (int i = 0; i < 9; i++)
            add_pixel((i % 2) ? pixel_t'(24'hFFFFFF) : pixel_t'(24'h000000));
        add_drains(3);
        for (int i = 0; i < 9; i++) add_pixel(pixel_t'(i < 3 ? 24'hFF00FF : 24'h00FF00));
        // pixel after a complete frame drops the pending results
        for (int i = 0; i < 4; i++) add_pixel(pixel_t'(24'hFFFFFF));
        wait_idle();
        write_reg(REG_SPARE_A, 11'd5);
        write_reg(REG_SPARE_B, 11'd2047);

        // size extremes, including zero and oversize values
        set_frame(0, 0);    add_frame(1, 1); add_frame(1, 1);
        set_frame(1, 6);    add_frame(1, 6);
        set_frame(7, 1);    add_frame(7, 1);
        set_frame(2047, 1); add_pixels(40); add_drains(2);
        set_frame(1, 2047); add_pixels(40); add_drains(2);
        set_frame(1024, 2); add_pixels(30); add_drains(2);

        // random phases: mostly whole frames, some broken ones and noise
        while (items_taken < 1500) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(w, h);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0: add_drains($urandom_range(1, 5));
                    1: begin
                        n = $urandom_range(1, w * h);
                        for (int i = 0; i < n; i++)
                            add_pixel(pixel_t'($urandom));
                        if ($urandom_range(0, 1)) add_drains($urandom_range(1, 4));
                    end
                    default: add_frame(w, h);
                endcase
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_mags.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
